// ===== hw/rtl/rrts_pkg.sv =====
// shared types and constants of the round-robin task scheduler
`timescale 1ns / 1ps
package rrts_pkg;
  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam logic [7:0] QUANTUM_RESET = 8'd10;

  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_DESTROY = 3'd2;
  localparam logic [2:0] CMD_YIELD = 3'd3;
  localparam logic [2:0] CMD_EXIT = 3'd4;

  localparam logic [1:0] ST_UNUSED = 2'd0;
  localparam logic [1:0] ST_READY = 2'd1;
  localparam logic [1:0] ST_RUNNING = 2'd2;
  localparam logic [1:0] ST_ZOMBIE = 2'd3;

  typedef struct packed {
    logic [2:0]        command;
    logic [SLOT_W-1:0] target_slot;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [SLOT_W-1:0] created_slot;
    logic [31:0]       created_id;
    logic              switched;
    logic [SLOT_W-1:0] previous_slot;
    logic [SLOT_W-1:0] current_slot;
    logic [31:0]       current_id;
  } out_item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] slot;
    logic              st_en;
    logic [1:0]        st;
    logic              id_en;
    logic [31:0]       id;
    logic              sl_en;
    logic [7:0]        sl;
    logic              rt_en;
    logic [31:0]       rt;
    logic              lk_en;
    logic [SLOT_W-1:0] lk;
  } cell_wr_t;

  typedef struct packed {
    logic [1:0]        st;
    logic [31:0]       id;
    logic [7:0]        sl;
    logic [31:0]       rt;
    logic [SLOT_W-1:0] lk;
  } cell_rd_t;
endpackage

// ===== hw/rtl/rrts_cell.sv =====
// one slot of the task table with its stage of the free-slot search chain
`timescale 1ns / 1ps
module rrts_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [rrts_pkg::SLOT_W-1:0]    idx,
  input  rrts_pkg::cell_wr_t             wr,
  input  logic                           scan_in,
  output logic                           scan_out,
  output logic                           hit,
  output rrts_pkg::cell_rd_t             rd
);
  logic [1:0]                  st_r;
  logic [31:0]                 id_r;
  logic [7:0]                  sl_r;
  logic [31:0]                 rt_r;
  logic [rrts_pkg::SLOT_W-1:0] lk_r;
  logic                        scan_r;
  logic                        sel;

  assign sel = wr.en && (wr.slot == idx);
  assign hit = scan_in && (idx != '0) && (st_r == rrts_pkg::ST_UNUSED);
  assign scan_out = scan_r;
  assign rd = '{st: st_r, id: id_r, sl: sl_r, rt: rt_r, lk: lk_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= (idx == '0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_UNUSED;
      id_r <= '0;
      sl_r <= '0;
      rt_r <= '0;
      scan_r <= 1'b0;
    end else begin
      scan_r <= scan_in && !hit;
      if (sel && wr.st_en) st_r <= wr.st;
      if (sel && wr.id_en) id_r <= wr.id;
      if (sel && wr.sl_en) sl_r <= wr.sl;
      if (sel && wr.rt_en) rt_r <= wr.rt;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && wr.lk_en) lk_r <= wr.lk;
  end
endmodule

// ===== hw/rtl/rrts_ctrl.sv =====
// command sequencer: ready list, running slot, id counter and result register
`timescale 1ns / 1ps
module rrts_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rrts_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rrts_pkg::out_item_t          out_item,
  input  logic                         cfg_we,
  input  logic [7:0]                   cfg_wdata,
  input  rrts_pkg::cell_rd_t           rd [rrts_pkg::NUM_SLOTS],
  input  logic [rrts_pkg::NUM_SLOTS-1:0] hit,
  input  logic                         scan_miss,
  output logic                         scan_start,
  output rrts_pkg::cell_wr_t           wr
);
  localparam int SW = rrts_pkg::SLOT_W;
  localparam int IW = rrts_pkg::IDX_W;
  localparam logic [3:0] S_IDLE = 4'd0, S_DISP = 4'd1, S_TICK = 4'd2, S_SCAN = 4'd3,
    S_APPEND = 4'd4, S_WALK = 4'd5, S_FREE = 4'd6, S_RS0 = 4'd7, S_RS1 = 4'd8,
    S_RS3 = 4'd9, S_DONE = 4'd10;

  logic [3:0]  st_r, st_nxt;
  logic [2:0]  cmd_r, cmd_nxt;
  logic [SW-1:0] tgt_r, tgt_nxt, before_r, before_nxt;
  logic        ok_r, ok_nxt;
  logic [SW-1:0] cslot_r, cslot_nxt;
  logic [31:0] cid_r, cid_nxt;
  logic [7:0]  quantum_r;
  logic [SW-1:0] head_r, head_nxt, tail_r, tail_nxt, run_r, run_nxt;
  logic        ne_r, ne_nxt;
  logic [31:0] next_id_r, next_id_nxt;
  logic [SW-1:0] nxt_r, nxt_nxt, app_r, app_nxt, cur_r, cur_nxt, prv_r, prv_nxt;
  logic        hp_r, hp_nxt, ret_r, ret_nxt;
  logic [rrts_pkg::CNT_W-1:0] n_r, n_nxt;
  logic        out_valid_r;
  rrts_pkg::out_item_t out_r;
  logic        load;
  logic [SW-1:0] hit_idx;
  logic [7:0]  tsl;

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;
  assign load = (st_r == S_DONE) && (!out_valid_r || !out_stall);
  assign tsl = rd[run_r[IW-1:0]].sl;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin
      if (hit[i]) hit_idx = hit_idx | SW'(i);
    end
  end

  always_comb begin
    st_nxt = st_r; cmd_nxt = cmd_r; tgt_nxt = tgt_r; before_nxt = before_r;
    ok_nxt = ok_r; cslot_nxt = cslot_r; cid_nxt = cid_r;
    head_nxt = head_r; tail_nxt = tail_r; run_nxt = run_r; ne_nxt = ne_r;
    next_id_nxt = next_id_r; nxt_nxt = nxt_r; app_nxt = app_r; cur_nxt = cur_r;
    prv_nxt = prv_r; hp_nxt = hp_r; ret_nxt = ret_r; n_nxt = n_r;
    scan_start = 1'b0;
    wr = '0;
    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt = in_item.command;
          tgt_nxt = in_item.target_slot;
          before_nxt = run_r;
          ok_nxt = 1'b1; cslot_nxt = '0; cid_nxt = '0;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (cmd_r)
          rrts_pkg::CMD_TICK: st_nxt = S_TICK;
          rrts_pkg::CMD_CREATE: begin
            scan_start = 1'b1;
            st_nxt = S_SCAN;
          end
          rrts_pkg::CMD_DESTROY: begin
            if (tgt_r == '0 || 32'(tgt_r) >= rrts_pkg::NUM_SLOTS) begin
              ok_nxt = 1'b0;
              st_nxt = S_DONE;
            end else if (ne_r) begin
              cur_nxt = head_r; hp_nxt = 1'b0; n_nxt = '0;
              st_nxt = S_WALK;
            end else begin
              st_nxt = S_FREE;
            end
          end
          rrts_pkg::CMD_YIELD: st_nxt = S_RS0;
          rrts_pkg::CMD_EXIT: begin
            if (run_r != '0) begin
              wr.en = 1'b1; wr.slot = run_r;
              wr.st_en = 1'b1; wr.st = rrts_pkg::ST_ZOMBIE;
              st_nxt = S_RS0;
            end else begin
              st_nxt = S_DONE;
            end
          end
          default: begin
            ok_nxt = 1'b0;
            st_nxt = S_DONE;
          end
        endcase
      end
      S_TICK: begin
        wr.en = 1'b1; wr.slot = run_r; wr.sl_en = 1'b1;
        if (tsl != '0) begin
          wr.rt_en = 1'b1;
          wr.rt = rd[run_r[IW-1:0]].rt + 32'd1;
        end
        if (tsl <= 8'd1) begin
          wr.sl = quantum_r;
          st_nxt = S_RS0;
        end else begin
          wr.sl = tsl - 8'd1;
          st_nxt = S_DONE;
        end
      end
      S_SCAN: begin
        if (|hit) begin
          wr.en = 1'b1; wr.slot = hit_idx;
          wr.st_en = 1'b1; wr.st = rrts_pkg::ST_READY;
          wr.id_en = 1'b1; wr.id = next_id_r;
          wr.sl_en = 1'b1; wr.sl = quantum_r;
          wr.rt_en = 1'b1; wr.rt = '0;
          cslot_nxt = hit_idx; cid_nxt = next_id_r;
          next_id_nxt = next_id_r + 32'd1;
          if (!ne_r) begin
            head_nxt = hit_idx; tail_nxt = hit_idx; ne_nxt = 1'b1;
            st_nxt = S_DONE;
          end else begin
            app_nxt = hit_idx; ret_nxt = 1'b0;
            st_nxt = S_APPEND;
          end
        end else if (scan_miss) begin
          ok_nxt = 1'b0;
          st_nxt = S_DONE;
        end
      end
      S_APPEND: begin
        wr.en = 1'b1; wr.slot = tail_r; wr.lk_en = 1'b1; wr.lk = app_r;
        tail_nxt = app_r;
        st_nxt = ret_r ? S_RS3 : S_DONE;
      end
      S_WALK: begin
        if (cur_r == tgt_r) begin
          if (!hp_r) begin
            if (cur_r == tail_r) ne_nxt = 1'b0;
            else head_nxt = rd[cur_r[IW-1:0]].lk;
          end else begin
            wr.en = 1'b1; wr.slot = prv_r; wr.lk_en = 1'b1;
            wr.lk = rd[cur_r[IW-1:0]].lk;
            if (cur_r == tail_r) tail_nxt = prv_r;
          end
          st_nxt = S_FREE;
        end else if (cur_r == tail_r ||
                     32'(n_r) + 32'd1 >= rrts_pkg::NUM_SLOTS) begin
          st_nxt = S_FREE;
        end else begin
          prv_nxt = cur_r; hp_nxt = 1'b1;
          cur_nxt = rd[cur_r[IW-1:0]].lk;
          n_nxt = n_r + 1'b1;
        end
      end
      S_FREE: begin
        wr.en = 1'b1; wr.slot = tgt_r;
        wr.st_en = 1'b1; wr.st = rrts_pkg::ST_UNUSED;
        wr.id_en = 1'b1; wr.id = '0;
        st_nxt = S_DONE;
      end
      S_RS0: begin
        nxt_nxt = '0;
        if (ne_r) begin
          nxt_nxt = head_r;
          if (head_r == tail_r) ne_nxt = 1'b0;
          else head_nxt = rd[head_r[IW-1:0]].lk;
        end
        st_nxt = ((ne_r ? head_r : '0) == run_r) ? S_DONE : S_RS1;
      end
      S_RS1: begin
        st_nxt = S_RS3;
        if (rd[run_r[IW-1:0]].st == rrts_pkg::ST_RUNNING) begin
          wr.en = 1'b1; wr.slot = run_r;
          wr.st_en = 1'b1; wr.st = rrts_pkg::ST_READY;
          if (!ne_r) begin
            head_nxt = run_r; tail_nxt = run_r; ne_nxt = 1'b1;
          end else begin
            app_nxt = run_r; ret_nxt = 1'b1;
            st_nxt = S_APPEND;
          end
        end
      end
      S_RS3: begin
        run_nxt = nxt_r;
        wr.en = 1'b1; wr.slot = nxt_r;
        wr.st_en = 1'b1; wr.st = rrts_pkg::ST_RUNNING;
        st_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      quantum_r <= rrts_pkg::QUANTUM_RESET;
      head_r <= '0; tail_r <= '0; ne_r <= 1'b0; run_r <= '0;
      next_id_r <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) quantum_r <= cfg_wdata;
      head_r <= head_nxt; tail_r <= tail_nxt; ne_r <= ne_nxt; run_r <= run_nxt;
      next_id_r <= next_id_nxt;
      if (load) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt; tgt_r <= tgt_nxt; before_r <= before_nxt;
    ok_r <= ok_nxt; cslot_r <= cslot_nxt; cid_r <= cid_nxt;
    nxt_r <= nxt_nxt; app_r <= app_nxt; cur_r <= cur_nxt; prv_r <= prv_nxt;
    hp_r <= hp_nxt; ret_r <= ret_nxt; n_r <= n_nxt;
    if (load) begin
      out_r.ok <= ok_r;
      out_r.created_slot <= cslot_r;
      out_r.created_id <= cid_r;
      out_r.switched <= (run_r != before_r);
      out_r.previous_slot <= before_r;
      out_r.current_slot <= run_r;
      out_r.current_id <= rd[run_r[IW-1:0]].id;
    end
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> !wr.en) else $error("slot write while idle");
  a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit)) else $error("more than one free slot claimed");
  a_run_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(run_r) < rrts_pkg::NUM_SLOTS) else $error("running slot out of range");
  a_scan_only_create: assert property (@(posedge clk) disable iff (!rst_n)
    (|hit) |-> (st_r == S_SCAN)) else $error("search hit outside create");
`endif
endmodule

// ===== hw/rtl/round_robin_task_scheduler.sv =====
// top level of the round-robin task scheduler: slot cells and sequencer
//
//   channel  ports                          payload
//   input    in_valid, in_stall, in_item    command, target_slot
//   result   out_valid, out_stall, out_item ok .. current_id
//   config   cfg_we, cfg_wdata              quantum_ticks
//
// one item at a time: create moves its search token one cell a cycle, and destroy
// walks the ready list one link a cycle
// synchronous reset puts slot 0 running with an empty ready list
// the next item is taken while a result waits under out_stall
`timescale 1ns / 1ps
module round_robin_task_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rrts_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output rrts_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);
  rrts_pkg::cell_wr_t wr;
  rrts_pkg::cell_rd_t rd [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::NUM_SLOTS-1:0] hit, scan_o;
  logic scan_start;

  for (genvar i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin : g_cell
    rrts_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .idx      (rrts_pkg::SLOT_W'(i)),
      .wr       (wr),
      .scan_in  ((i == 0) ? scan_start : scan_o[(i == 0) ? 0 : i - 1]),
      .scan_out (scan_o[i]),
      .hit      (hit[i]),
      .rd       (rd[i])
    );
  end

  rrts_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .rd         (rd),
    .hit        (hit),
    .scan_miss  (scan_o[rrts_pkg::NUM_SLOTS-1]),
    .scan_start (scan_start),
    .wr         (wr)
  );
endmodule
